/* hw/rtl/tcf_pkg.sv */
package tcf_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int SEQ_BITS        = 16;
  localparam int ID_W            = 16;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_ANY  = 2'd1,
    KIND_DEQ0 = 2'd2,
    KIND_DEQ1 = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    kind_t           kind;
    logic            item_class;
    logic [ID_W-1:0] item_id;
  } in_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] out_id;
    logic            out_class;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qcmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

/* hw/rtl/tcf_ram.sv */
module tcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/tcf_qptr.sv */
module tcf_qptr #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tcf_pkg::qcmd_t           cmd,
  output logic [$clog2(DEPTH)-1:0] head,
  output logic [$clog2(DEPTH)-1:0] tail,
  output tcf_pkg::qstat_t          stat
);
  import tcf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.push) begin
      tail_nxt  = (tail_r == LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      head_nxt  = (head_r == LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign head       = head_r;
  assign tail       = tail_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));

endmodule

/* hw/rtl/two_class_fifo_oldest_dequeue.sv */
// Two-class FIFO with oldest-first dequeue.
//
// Requests arrive on in_valid/in_ready/in_data. An enqueue stores the id in the
// queue of its class, stamped with a 16-bit arrival number. A class dequeue
// pops the head of that queue; a dequeue-any pops the older of the two heads,
// or the only non-empty one. Each request gives exactly one result on
// out_valid/out_ready/out_data, with a status of ok, empty or full.
//
// An enqueue, or a dequeue that finds its queue(s) empty, has its result
// registered in the cycle after acceptance. A dequeue that pops passes ST_READ
// first, as the queue entries live in synchronous RAMs with a registered read.
// Throughput is one enqueue per cycle while the receiver keeps up; a popping
// dequeue holds off new requests until its result is registered.
//
// A new request is taken while the result register is empty or being drained
// in the same cycle; when the receiver stalls, the result waits in the output
// register and in_ready drops until it is taken. Synchronous reset empties both
// queues and clears the arrival counter; no clearing pass is needed.
module two_class_fifo_oldest_dequeue #(
  parameter int QUEUE_DEPTH = tcf_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = tcf_pkg::ID_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tcf_pkg::out_t out_data
);
  import tcf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int EW = SEQ_BITS + ID_BITS;

  state_t state_r, state_nxt;
  kind_t  req_kind_r;
  logic   out_valid_r, out_valid_nxt;
  out_t   out_r, out_nxt;
  logic [SEQ_BITS-1:0] seq_r, seq_nxt;

  qcmd_t  cmd0, cmd1;
  qstat_t stat0, stat1;
  logic [PW-1:0] head0, tail0, head1, tail1;
  logic [EW-1:0] rd0, rd1, wdata;

  logic in_acc;
  logic is_enq, tgt_empty, tgt_full;
  logic sel1;
  logic [SEQ_BITS-1:0] diff;
  logic [ID_BITS+ID_W-1:0] id_in_ext;
  logic [ID_BITS-1:0]      id_in;
  logic [ID_BITS-1:0]      pop_id;
  logic [ID_W+ID_BITS-1:0] pop_id_ext;

  tcf_qptr #(.DEPTH(QUEUE_DEPTH)) u_qptr0 (
    .clk(clk), .rst_n(rst_n), .cmd(cmd0), .head(head0), .tail(tail0), .stat(stat0)
  );

  tcf_qptr #(.DEPTH(QUEUE_DEPTH)) u_qptr1 (
    .clk(clk), .rst_n(rst_n), .cmd(cmd1), .head(head1), .tail(tail1), .stat(stat1)
  );

  tcf_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram0 (
    .clk(clk), .we(cmd0.push), .waddr(tail0), .wdata(wdata), .raddr(head0), .rdata(rd0)
  );

  tcf_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram1 (
    .clk(clk), .we(cmd1.push), .waddr(tail1), .wdata(wdata), .raddr(head1), .rdata(rd1)
  );

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  assign id_in_ext = {ID_BITS'(0), in_data.item_id};
  assign id_in     = id_in_ext[ID_BITS-1:0];
  assign wdata     = {seq_r, id_in};

  assign is_enq = (in_data.kind == KIND_ENQ);
  assign tgt_full = in_data.item_class ? stat1.full : stat0.full;

  always_comb begin
    unique case (in_data.kind)
      KIND_ENQ:  tgt_empty = 1'b0;
      KIND_ANY:  tgt_empty = stat0.empty && stat1.empty;
      KIND_DEQ0: tgt_empty = stat0.empty;
      KIND_DEQ1: tgt_empty = stat1.empty;
      default:   tgt_empty = 1'b1;
    endcase
  end

  // Heads are read every cycle; the data seen in ST_READ belongs to the heads
  // that were current when the request was accepted, since nothing moves them
  // in between. A head's sequence number is older when s0 - s1 is negative.
  assign diff = rd0[EW-1:ID_BITS] - rd1[EW-1:ID_BITS];

  always_comb begin
    unique case (req_kind_r)
      KIND_DEQ0: sel1 = 1'b0;
      KIND_DEQ1: sel1 = 1'b1;
      KIND_ANY: begin
        if (stat0.empty) begin
          sel1 = 1'b1;
        end else if (stat1.empty) begin
          sel1 = 1'b0;
        end else begin
          sel1 = !diff[SEQ_BITS-1];
        end
      end
      default:   sel1 = 1'b0;
    endcase
  end

  assign pop_id     = sel1 ? rd1[ID_BITS-1:0] : rd0[ID_BITS-1:0];
  assign pop_id_ext = {ID_W'(0), pop_id};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && !is_enq && !tgt_empty) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs, queue commands and the arrival counter.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    cmd0          = '0;
    cmd1          = '0;
    seq_nxt       = seq_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_enq) begin
            out_valid_nxt       = 1'b1;
            out_nxt.out_id      = '0;
            out_nxt.out_class   = 1'b0;
            if (tgt_full) begin
              out_nxt.status = STAT_FULL;
            end else begin
              out_nxt.status = STAT_OK;
              cmd0.push      = !in_data.item_class;
              cmd1.push      = in_data.item_class;
              seq_nxt        = seq_r + 1'b1;
            end
          end else if (tgt_empty) begin
            out_valid_nxt     = 1'b1;
            out_nxt.status    = STAT_EMPTY;
            out_nxt.out_id    = '0;
            out_nxt.out_class = 1'b0;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt     = 1'b1;
        out_nxt.status    = STAT_OK;
        out_nxt.out_id    = pop_id_ext[ID_W-1:0];
        out_nxt.out_class = sel1;
        cmd0.pop          = !sel1;
        cmd1.pop          = sel1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seq_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seq_r       <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_acc) begin
      req_kind_r <= in_data.kind;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_read_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> !out_valid_r)
    else $error("read cycle entered with an undelivered result");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> out_valid_r && state_r == ST_IDLE)
    else $error("pop did not produce a result");

  a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_enq |=> out_valid_r && out_r.out_id == '0)
    else $error("enqueue result missing or malformed");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> !(sel1 ? stat1.empty : stat0.empty))
    else $error("pop from an empty queue");

endmodule
